// File: rtl/core/sslp_pkg.sv
// Shared definitions for the servo slew-limited position unit.
// Holds request codes, register indexes, defaults and the flag structs.
// Used by sslp_step, the top level and the checker; depends on nothing.
package sslp_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_BITS   = 3;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_SET     = 2'd1,
        FUNC_FORCE   = 2'd2,
        FUNC_DISABLE = 2'd3
    } func_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_POS    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_POS    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOFT_LOWER = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOFT_UPPER = 3'd4;

    // Control flags of the position state.
    typedef struct packed {
        logic position_valid;
        logic goal_valid;
        logic off_flag;
    } state_flags_t;

    // Single-bit fields of one result.
    typedef struct packed {
        logic accepted;
        logic drive_valid;
        logic drive_off;
        logic moving;
        logic inverted;
        logic ready_res;
    } result_flags_t;

endpackage

// File: rtl/core/servo_slew_limited_position_unit.sv
// Top level of the servo slew-limited position unit.
// Holds the configuration, position state, request and result registers;
// the per-request update is in sslp_step. Depends on sslp_pkg and sslp_step.
//
//   Channel   Handshake              Fields
//   --------  ---------------------  -----------------------------------------------
//   request   in_valid / in_stall    func, target_value, use_soft_limits, jump_now
//   result    out_valid / out_stall  accepted, drive_valid, drive_value, drive_off,
//                                    moving, inverted, ready_res
//   config    cfg_we                 cfg_index, cfg_data
//
// A request is registered on acceptance and its result is registered from the request
// register as it advances; one request is taken every cycle unless in_stall is asserted.
// The position state is updated as a request moves into the result register.
// A stalled result holds the request register, which then asserts in_stall.
// rst_n clears the state, the valid flags and the configuration to defaults.
module servo_slew_limited_position_unit #(
    parameter int POS_BITS = sslp_pkg::POS_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [POS_BITS-1:0]               target_value,
    input  logic                              use_soft_limits,
    input  logic                              jump_now,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic                              drive_valid,
    output logic [POS_BITS-1:0]               drive_value,
    output logic                              drive_off,
    output logic                              moving,
    output logic                              inverted,
    output logic                              ready_res,
    input  logic                              cfg_we,
    input  logic [sslp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [POS_BITS-1:0]               cfg_data
);

    logic [POS_BITS-1:0]     min_pos_reg;
    logic [POS_BITS-1:0]     max_pos_reg;
    logic [POS_BITS-1:0]     step_limit_reg;
    logic [POS_BITS-1:0]     soft_lower_reg;
    logic [POS_BITS-1:0]     soft_upper_reg;

    logic [POS_BITS-1:0]     position_reg;
    logic [POS_BITS-1:0]     goal_reg;
    logic [POS_BITS-1:0]     last_request_reg;
    sslp_pkg::state_flags_t  flags_reg;

    logic [POS_BITS-1:0]     position_next;
    logic [POS_BITS-1:0]     goal_next;
    logic [POS_BITS-1:0]     last_request_next;
    sslp_pkg::state_flags_t  flags_next;

    logic                    req_valid_reg;
    logic [1:0]              func_reg;
    logic [POS_BITS-1:0]     target_value_reg;
    logic                    use_soft_limits_reg;
    logic                    jump_now_reg;

    logic                    out_valid_reg;
    sslp_pkg::result_flags_t result_reg;
    sslp_pkg::result_flags_t result_next;
    logic [POS_BITS-1:0]     drive_value_reg;
    logic [POS_BITS-1:0]     drive_value_next;

    logic                    advance;

    assign advance  = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_pos_reg    <= '0;
            max_pos_reg    <= '1;
            step_limit_reg <= '0;
            soft_lower_reg <= '0;
            soft_upper_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sslp_pkg::REG_MIN_POS:    min_pos_reg    <= cfg_data;
                sslp_pkg::REG_MAX_POS:    max_pos_reg    <= cfg_data;
                sslp_pkg::REG_STEP_LIMIT: step_limit_reg <= cfg_data;
                sslp_pkg::REG_SOFT_LOWER: soft_lower_reg <= cfg_data;
                sslp_pkg::REG_SOFT_UPPER: soft_upper_reg <= cfg_data;
                default:                  min_pos_reg    <= min_pos_reg;
            endcase
        end
    end

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            func_reg            <= func;
            target_value_reg    <= target_value;
            use_soft_limits_reg <= use_soft_limits;
            jump_now_reg        <= jump_now;
        end
    end

    sslp_step #(
        .POS_BITS (POS_BITS)
    ) u_step (
        .min_pos           (min_pos_reg),
        .max_pos           (max_pos_reg),
        .step_limit        (step_limit_reg),
        .soft_lower        (soft_lower_reg),
        .soft_upper        (soft_upper_reg),
        .func              (func_reg),
        .target_value      (target_value_reg),
        .use_soft_limits   (use_soft_limits_reg),
        .jump_now          (jump_now_reg),
        .position          (position_reg),
        .goal              (goal_reg),
        .last_request      (last_request_reg),
        .flags             (flags_reg),
        .position_next     (position_next),
        .goal_next         (goal_next),
        .last_request_next (last_request_next),
        .flags_next        (flags_next),
        .result            (result_next),
        .drive_value       (drive_value_next)
    );

    // Position state and result register advance together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            position_reg     <= '0;
            goal_reg         <= '0;
            last_request_reg <= '0;
            flags_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                position_reg     <= position_next;
                goal_reg         <= goal_next;
                last_request_reg <= last_request_next;
                flags_reg        <= flags_next;
                out_valid_reg    <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            result_reg      <= result_next;
            drive_value_reg <= drive_value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = result_reg.accepted;
    assign drive_valid = result_reg.drive_valid;
    assign drive_value = drive_value_reg;
    assign drive_off   = result_reg.drive_off;
    assign moving      = result_reg.moving;
    assign inverted    = result_reg.inverted;
    assign ready_res   = result_reg.ready_res;

endmodule

// File: rtl/core/sslp_step.sv
// Combinational update of the servo position state for one request.
// Computes the next state and the result fields from the current state,
// the configuration and the request. Depends on sslp_pkg.
module sslp_step #(
    parameter int POS_BITS = sslp_pkg::POS_BITS_DEFAULT
) (
    input  logic [POS_BITS-1:0]     min_pos,
    input  logic [POS_BITS-1:0]     max_pos,
    input  logic [POS_BITS-1:0]     step_limit,
    input  logic [POS_BITS-1:0]     soft_lower,
    input  logic [POS_BITS-1:0]     soft_upper,
    input  logic [1:0]              func,
    input  logic [POS_BITS-1:0]     target_value,
    input  logic                    use_soft_limits,
    input  logic                    jump_now,
    input  logic [POS_BITS-1:0]     position,
    input  logic [POS_BITS-1:0]     goal,
    input  logic [POS_BITS-1:0]     last_request,
    input  sslp_pkg::state_flags_t  flags,
    output logic [POS_BITS-1:0]     position_next,
    output logic [POS_BITS-1:0]     goal_next,
    output logic [POS_BITS-1:0]     last_request_next,
    output sslp_pkg::state_flags_t  flags_next,
    output sslp_pkg::result_flags_t result,
    output logic [POS_BITS-1:0]     drive_value
);

    logic [POS_BITS-1:0] lo_clamped;
    logic [POS_BITS-1:0] up_clamped;
    logic [POS_BITS-1:0] target_clamped;
    logic [POS_BITS-1:0] forced_pos;
    logic [POS_BITS-1:0] diff_up;
    logic [POS_BITS-1:0] diff_down;
    logic                at_goal_now;

    function automatic logic [POS_BITS-1:0] clamp_range(
        input logic [POS_BITS-1:0] v,
        input logic [POS_BITS-1:0] lo,
        input logic [POS_BITS-1:0] hi
    );
        logic [POS_BITS-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic is_at_goal(
        input logic                pv,
        input logic                gv,
        input logic [POS_BITS-1:0] p,
        input logic [POS_BITS-1:0] g
    );
        return (pv == gv) && (!pv || (p == g));
    endfunction

    assign lo_clamped  = clamp_range(soft_lower, min_pos, max_pos);
    assign up_clamped  = clamp_range(soft_upper, min_pos, max_pos);
    assign forced_pos  = clamp_range(target_value, min_pos, max_pos);
    assign diff_up     = goal - position;
    assign diff_down   = position - goal;
    assign at_goal_now = is_at_goal(flags.position_valid, flags.goal_valid, position, goal);

    // Target clamp: hard range tests max first; soft limits test the upper end
    // first, and equal soft limits count as the inverted direction.
    always_comb
    begin
        if (!use_soft_limits) begin
            if (target_value > max_pos) begin
                target_clamped = max_pos;
            end else if (target_value < min_pos) begin
                target_clamped = min_pos;
            end else begin
                target_clamped = target_value;
            end
        end else if (lo_clamped < up_clamped) begin
            if (target_value > up_clamped) begin
                target_clamped = up_clamped;
            end else if (target_value < lo_clamped) begin
                target_clamped = lo_clamped;
            end else begin
                target_clamped = target_value;
            end
        end else begin
            if (target_value < up_clamped) begin
                target_clamped = up_clamped;
            end else if (target_value > lo_clamped) begin
                target_clamped = lo_clamped;
            end else begin
                target_clamped = target_value;
            end
        end
    end

    always_comb
    begin
        position_next      = position;
        goal_next          = goal;
        last_request_next  = last_request;
        flags_next         = flags;
        result.accepted    = 1'b0;
        result.drive_valid = 1'b0;
        result.drive_off   = 1'b0;
        drive_value        = '0;

        unique case (sslp_pkg::func_t'(func))
            sslp_pkg::FUNC_TICK:
            begin
                if (!flags.off_flag && flags.goal_valid && !at_goal_now) begin
                    if (!flags.position_valid || (step_limit == '0)) begin
                        position_next = goal;
                    end else if (goal > position) begin
                        position_next = (diff_up > step_limit) ? position + step_limit : goal;
                    end else begin
                        position_next = (diff_down > step_limit) ? position - step_limit : goal;
                    end
                    flags_next.position_valid = 1'b1;
                    result.drive_valid        = 1'b1;
                    drive_value               = position_next;
                end
            end
            sslp_pkg::FUNC_SET:
            begin
                if (target_value == '0) begin
                    result.accepted = 1'b0;
                end else if (flags.position_valid && (target_value == position)) begin
                    goal_next             = position;
                    flags_next.goal_valid = 1'b1;
                    result.accepted       = 1'b1;
                end else begin
                    // The output is re-enabled even when the request repeats.
                    flags_next.off_flag = 1'b0;
                    if (last_request != target_value) begin
                        last_request_next     = target_value;
                        goal_next             = target_clamped;
                        flags_next.goal_valid = 1'b1;
                        result.accepted       = 1'b1;
                        if (jump_now) begin
                            position_next             = target_clamped;
                            flags_next.position_valid = 1'b1;
                            result.drive_valid        = 1'b1;
                            drive_value               = target_clamped;
                        end
                    end
                end
            end
            sslp_pkg::FUNC_FORCE:
            begin
                position_next             = forced_pos;
                goal_next                 = forced_pos;
                flags_next.position_valid = 1'b1;
                flags_next.goal_valid     = 1'b1;
            end
            sslp_pkg::FUNC_DISABLE:
            begin
                if (!flags.off_flag) begin
                    flags_next.off_flag = 1'b1;
                    result.drive_off    = 1'b1;
                end
            end
            default:
            begin
                flags_next = flags;
            end
        endcase

        result.moving    = !is_at_goal(flags_next.position_valid, flags_next.goal_valid,
                                       position_next, goal_next);
        result.inverted  = up_clamped < lo_clamped;
        result.ready_res = flags_next.position_valid;
    end

endmodule

// File: rtl/core/sslp_checker.sv
// Port-level checks for the servo slew-limited position unit.
// Watches the top level's ports only and is attached by the bind below.
// Depends on sslp_pkg and servo_slew_limited_position_unit.
module sslp_checker #(
    parameter int POS_BITS = sslp_pkg::POS_BITS_DEFAULT
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               accepted,
    input logic                               drive_valid,
    input logic [POS_BITS-1:0]                drive_value,
    input logic                               drive_off,
    input logic                               moving,
    input logic                               ready_res
);

    // Only a disable request switches the output off; it drives and accepts nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_off |-> !drive_valid && !accepted)
    else $error("drive_off seen together with drive_valid or accepted");

    // A result that drives nothing carries a zero drive value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !drive_valid |-> drive_value == '0)
    else $error("drive_value not zero without drive_valid");

    // Once the position is known it stays known for every later result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && ready_res) ##1 out_valid |-> ready_res)
    else $error("ready_res dropped after being set");

    // A stalled result is held unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_value)
            && $stable(drive_valid) && $stable(moving))
    else $error("stalled result changed");

endmodule

bind servo_slew_limited_position_unit sslp_checker #(
    .POS_BITS (POS_BITS)
) u_sslp_checker (.*);

// File: tb/servo_result_checker.sv
// Result checker for the servo slew-limited position unit.
// Watches the request, result and register write ports, predicts each result
// and compares it; depends on sslp_pkg only.
module servo_result_checker
    import sslp_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                func,
    input  logic [POS_BITS-1:0]       target_value,
    input  logic                      use_soft_limits,
    input  logic                      jump_now,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      accepted,
    input  logic                      drive_valid,
    input  logic [POS_BITS-1:0]       drive_value,
    input  logic                      drive_off,
    input  logic                      moving,
    input  logic                      inverted,
    input  logic                      ready_res,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [POS_BITS-1:0]       cfg_data,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        result_flags_t       flags;
        logic [POS_BITS-1:0] value;
    } servo_result_t;

    logic [POS_BITS-1:0] min_pos_r;
    logic [POS_BITS-1:0] max_pos_r;
    logic [POS_BITS-1:0] step_r;
    logic [POS_BITS-1:0] soft_lo_r;
    logic [POS_BITS-1:0] soft_hi_r;
    logic [POS_BITS-1:0] position;
    logic [POS_BITS-1:0] goal;
    logic [POS_BITS-1:0] last_request;
    logic                position_known;
    logic                goal_known;
    logic                output_off;
    servo_result_t       expected_results[$];

    function automatic logic [POS_BITS-1:0] fit_range(input logic [POS_BITS-1:0] v);
        if (v < min_pos_r)
            return min_pos_r;
        if (v > max_pos_r)
            return max_pos_r;
        return v;
    endfunction

    function automatic logic settled();
        if (position_known != goal_known)
            return 1'b0;
        return !position_known || position == goal;
    endfunction

    // Plain targets test max first; soft limits are first pulled into min/max.
    function automatic logic [POS_BITS-1:0] clamp_goal(input logic [POS_BITS-1:0] v,
                                                        input logic soft_sel);
        logic [POS_BITS-1:0] lo;
        logic [POS_BITS-1:0] up;
        if (!soft_sel)
        begin
            if (v > max_pos_r)
                return max_pos_r;
            if (v < min_pos_r)
                return min_pos_r;
            return v;
        end
        lo = fit_range(soft_lo_r);
        up = fit_range(soft_hi_r);
        if (lo < up)
        begin
            if (v > up)
                return up;
            if (v < lo)
                return lo;
            return v;
        end
        // Inverted direction, which also covers equal soft limits.
        if (v < up)
            return up;
        if (v > lo)
            return lo;
        return v;
    endfunction

    function automatic servo_result_t advance_servo(input func_t op,
                                                    input logic [POS_BITS-1:0] v,
                                                    input logic soft_sel,
                                                    input logic jump);
        servo_result_t r;
        r = '0;
        case (op)
            FUNC_TICK:
            begin
                if (!output_off && goal_known && !settled())
                begin
                    if (!position_known || step_r == '0)
                        position = goal;
                    else if (goal > position)
                        position = (goal - position > step_r) ? position + step_r : goal;
                    else
                        position = (position - goal > step_r) ? position - step_r : goal;
                    position_known = 1'b1;
                    r.flags.drive_valid = 1'b1;
                    r.value = position;
                end
            end
            FUNC_SET:
            begin
                if (v != '0)
                begin
                    if (position_known && v == position)
                    begin
                        // Already there: no re-enable and no request memory update.
                        goal = position;
                        goal_known = 1'b1;
                        r.flags.accepted = 1'b1;
                    end
                    else
                    begin
                        // A repeated value is refused, but still re-enables the output.
                        output_off = 1'b0;
                        if (last_request != v)
                        begin
                            last_request = v;
                            goal = clamp_goal(v, soft_sel);
                            goal_known = 1'b1;
                            if (jump)
                            begin
                                position = goal;
                                position_known = 1'b1;
                                r.flags.drive_valid = 1'b1;
                                r.value = position;
                            end
                            r.flags.accepted = 1'b1;
                        end
                    end
                end
            end
            FUNC_FORCE:
            begin
                position = fit_range(v);
                position_known = 1'b1;
                goal = position;
                goal_known = 1'b1;
            end
            default:
            begin
                if (!output_off)
                begin
                    output_off = 1'b1;
                    r.flags.drive_off = 1'b1;
                end
            end
        endcase
        r.flags.moving = !settled();
        r.flags.inverted = fit_range(soft_hi_r) < fit_range(soft_lo_r);
        r.flags.ready_res = position_known;
        return r;
    endfunction

    task automatic compare_result(input servo_result_t want, input servo_result_t got);
        string diffs;
        diffs = "";
        if (want.flags.accepted !== got.flags.accepted)
            diffs = {diffs, " accepted"};
        if (want.flags.drive_valid !== got.flags.drive_valid)
            diffs = {diffs, " drive_valid"};
        if (want.value !== got.value)
            diffs = {diffs, " drive_value"};
        if (want.flags.drive_off !== got.flags.drive_off)
            diffs = {diffs, " drive_off"};
        if (want.flags.moving !== got.flags.moving)
            diffs = {diffs, " moving"};
        if (want.flags.inverted !== got.flags.inverted)
            diffs = {diffs, " inverted"};
        if (want.flags.ready_res !== got.flags.ready_res)
            diffs = {diffs, " ready_res"};
        if (diffs != "")
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("result mismatch in%s: expected acc=%0b dv=%0b val=%0d %s",
                         diffs, want.flags.accepted, want.flags.drive_valid, want.value,
                         $sformatf("off=%0b mov=%0b inv=%0b rdy=%0b",
                                   want.flags.drive_off, want.flags.moving,
                                   want.flags.inverted, want.flags.ready_res));
                $display("    got acc=%0b dv=%0b val=%0d off=%0b mov=%0b inv=%0b rdy=%0b",
                         got.flags.accepted, got.flags.drive_valid, got.value,
                         got.flags.drive_off, got.flags.moving, got.flags.inverted,
                         got.flags.ready_res);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        servo_result_t got;
        servo_result_t want;
        if (!rst_n)
        begin
            min_pos_r = '0;
            max_pos_r = '1;
            step_r = '0;
            soft_lo_r = '0;
            soft_hi_r = '0;
            position = '0;
            goal = '0;
            last_request = '0;
            position_known = 1'b0;
            goal_known = 1'b0;
            output_off = 1'b0;
            expected_results.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            // Results are checked before new requests are predicted, so a result can
            // never be matched against the request taken at the same edge.
            if (out_valid && !out_stall)
            begin
                got.flags.accepted = accepted;
                got.flags.drive_valid = drive_valid;
                got.flags.drive_off = drive_off;
                got.flags.moving = moving;
                got.flags.inverted = inverted;
                got.flags.ready_res = ready_res;
                got.value = drive_value;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with no request outstanding: val=%0d", drive_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_result(want, got);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_POS:    min_pos_r = cfg_data;
                    REG_MAX_POS:    max_pos_r = cfg_data;
                    REG_STEP_LIMIT: step_r = cfg_data;
                    REG_SOFT_LOWER: soft_lo_r = cfg_data;
                    REG_SOFT_UPPER: soft_hi_r = cfg_data;
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_results.push_back(advance_servo(func_t'(func), target_value,
                                                         use_soft_limits, jump_now));
            pending = expected_results.size();
        end
    end

endmodule

// File: tb/servo_slew_limited_position_unit_tb.sv
// Top of the servo slew-limited position unit testbench: clock, reset, register
// loads, directed and random requests, random result stalls and the verdict.
// Depends on sslp_pkg, the block and servo_result_checker.
module servo_slew_limited_position_unit_tb;
    import sslp_pkg::*;

    localparam int POS_W       = POS_BITS_DEFAULT;
    localparam int PHASES      = 9;
    localparam int RANDOM_ITEMS_PER_PHASE = 76;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    func_t                     func;
    logic [POS_W-1:0]          target_value;
    logic                      use_soft_limits;
    logic                      jump_now;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      accepted;
    logic                      drive_valid;
    logic [POS_W-1:0]          drive_value;
    logic                      drive_off;
    logic                      moving;
    logic                      inverted;
    logic                      ready_res;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [POS_W-1:0]          cfg_data;
    int                        fail_count;
    int                        pending;

    logic                      quiet_in;
    logic                      quiet_out;
    logic                      pressure_on;
    logic                      hold_used;
    int                        hold_left;
    int                        cycle_count = 0;
    logic [POS_W-1:0]          cur_min;
    logic [POS_W-1:0]          cur_max;
    logic [POS_W-1:0]          cur_soft_lo;
    logic [POS_W-1:0]          cur_soft_hi;
    logic [POS_W-1:0]          recent_targets[$];

    servo_slew_limited_position_unit #(
        .POS_BITS(POS_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .target_value(target_value),
        .use_soft_limits(use_soft_limits),
        .jump_now(jump_now),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .accepted(accepted),
        .drive_valid(drive_valid),
        .drive_value(drive_value),
        .drive_off(drive_off),
        .moving(moving),
        .inverted(inverted),
        .ready_res(ready_res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    servo_result_checker #(
        .POS_BITS(POS_W)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .target_value(target_value),
        .use_soft_limits(use_soft_limits),
        .jump_now(jump_now),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .accepted(accepted),
        .drive_valid(drive_valid),
        .drive_value(drive_value),
        .drive_off(drive_off),
        .moving(moving),
        .inverted(inverted),
        .ready_res(ready_res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[servo_slew_limited_position_unit] ERROR");
            $finish;
        end
    end

    // Result side: random stalls, a quiet stretch, and one long hold-off that lets
    // the block fill up while requests keep coming.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end
        else if (pressure_on && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (quiet_out)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 32);
    end

    task automatic send_request(input func_t f, input logic [POS_W-1:0] v,
                                input logic soft_sel, input logic jump);
        while (!quiet_in && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        target_value <= v;
        use_soft_limits <= soft_sel;
        jump_now <= jump;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (f == FUNC_SET || f == FUNC_FORCE)
        begin
            recent_targets.push_back(v);
            if (recent_targets.size() > 8)
                void'(recent_targets.pop_front());
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input logic [POS_W-1:0] lo_lim, input logic [POS_W-1:0] hi_lim,
                                 input logic [POS_W-1:0] step, input logic [POS_W-1:0] soft_a,
                                 input logic [POS_W-1:0] soft_b);
        cur_min = lo_lim;
        cur_max = hi_lim;
        cur_soft_lo = soft_a;
        cur_soft_hi = soft_b;
        cfg_we <= 1'b1;
        cfg_index <= REG_MIN_POS;
        cfg_data <= lo_lim;
        @(posedge clk);
        cfg_index <= REG_MAX_POS;
        cfg_data <= hi_lim;
        @(posedge clk);
        cfg_index <= REG_STEP_LIMIT;
        cfg_data <= step;
        @(posedge clk);
        cfg_index <= REG_SOFT_LOWER;
        cfg_data <= soft_a;
        @(posedge clk);
        cfg_index <= REG_SOFT_UPPER;
        cfg_data <= soft_b;
        @(posedge clk);
        // Indexes past the last register must be ignored.
        cfg_index <= CFG_INDEX_BITS'($urandom_range(REG_SOFT_UPPER + 1,
                                                    (1 << CFG_INDEX_BITS) - 1));
        cfg_data <= POS_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_target();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel == 2)
            return POS_W'(1);
        if (sel <= 6 && recent_targets.size() != 0)
            return recent_targets[$urandom_range(0, recent_targets.size() - 1)];
        if (sel == 7)
            return cur_min;
        if (sel == 8)
            return cur_max;
        if (sel == 9)
            return cur_soft_lo;
        if (sel == 10)
            return cur_soft_hi;
        if (sel == 11)
            return cur_min - POS_W'(1);
        return POS_W'($urandom);
    endfunction

    task automatic run_directed();
        send_request(FUNC_TICK, '1, 1'b1, 1'b1);
        send_request(FUNC_SET, '0, 1'b0, 1'b1);
        send_request(FUNC_SET, 16'd500, 1'b0, 1'b0);
        send_request(FUNC_TICK, '0, 1'b0, 1'b0);
        send_request(FUNC_SET, 16'd500, 1'b0, 1'b0);
        send_request(FUNC_DISABLE, '0, 1'b0, 1'b0);
        send_request(FUNC_DISABLE, '1, 1'b1, 1'b1);
        send_request(FUNC_TICK, '0, 1'b0, 1'b0);
        send_request(FUNC_SET, 16'd800, 1'b0, 1'b0);
        send_request(FUNC_SET, 16'd800, 1'b0, 1'b1);
        send_request(FUNC_TICK, '0, 1'b0, 1'b0);
        send_request(FUNC_FORCE, '1, 1'b0, 1'b0);
        send_request(FUNC_FORCE, '0, 1'b1, 1'b1);
        send_request(FUNC_SET, '1, 1'b1, 1'b1);
        send_request(FUNC_SET, 16'd1, 1'b1, 1'b0);
        send_request(FUNC_TICK, '0, 1'b0, 1'b0);
        send_request(FUNC_SET, 16'd30, 1'b0, 1'b1);
        send_request(FUNC_SET, 16'd65000, 1'b0, 1'b0);
        send_request(FUNC_DISABLE, '0, 1'b0, 1'b0);
        send_request(FUNC_FORCE, 16'd2000, 1'b0, 1'b0);
        send_request(FUNC_TICK, '0, 1'b0, 1'b0);
        // Same value as the position: accepted, but the output stays off.
        send_request(FUNC_SET, 16'd2000, 1'b0, 1'b0);
        send_request(FUNC_TICK, '0, 1'b0, 1'b0);
        send_request(FUNC_SET, 16'd3333, 1'b1, 1'b0);
        send_request(FUNC_TICK, '0, 1'b0, 1'b0);
    endtask

    // Mostly a new target followed by ticks that slew toward it, with forced
    // positions, disables and unrelated noise mixed in.
    task automatic run_random(input int quota);
        int sent;
        int kind;
        int ticks;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(0, 19);
            if (kind <= 11)
            begin
                send_request(FUNC_SET, pick_target(), 1'($urandom), ($urandom_range(0, 3) == 0));
                ticks = $urandom_range(1, 8);
            end
            else if (kind <= 14)
            begin
                send_request(FUNC_FORCE, pick_target(), 1'($urandom), 1'($urandom));
                ticks = $urandom_range(0, 3);
            end
            else if (kind <= 16)
            begin
                send_request(FUNC_DISABLE, POS_W'($urandom), 1'($urandom), 1'($urandom));
                ticks = $urandom_range(0, 2);
            end
            else
            begin
                send_request(func_t'($urandom_range(0, 3)), POS_W'($urandom), 1'($urandom),
                             1'($urandom));
                ticks = 0;
            end
            sent++;
            repeat (ticks)
            begin
                send_request(FUNC_TICK, POS_W'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int phase);
        case (phase)
            0: load_settings(16'd100, 16'd60000, 16'd0, 16'd1000, 16'd5000);
            1: load_settings(16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535);
            2: load_settings(16'd0, 16'd65535, 16'd1, 16'd65535, 16'd0);
            3: load_settings(16'd200, 16'd50000, 16'd37, 16'd4000, 16'd4000);
            4: load_settings(16'd50000, 16'd1000, 16'd500, 16'd100, 16'd60000);
            5: load_settings(16'd0, 16'd65535, 16'd65535, 16'd30000, 16'd20000);
            6: load_settings(16'd1234, 16'd43210, 16'd2000, 16'd0, 16'd65535);
            7: load_settings(16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd65535);
            default: load_settings(16'd0, 16'd0, 16'd65535, 16'd0, 16'd0);
        endcase
        quiet_in = (phase == 3 || phase == 5);
        quiet_out <= (phase == 3);
        pressure_on <= (phase == 5);
        if (phase == 0)
            run_directed();
        else
            run_random(RANDOM_ITEMS_PER_PHASE);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_TICK;
        target_value = '0;
        use_soft_limits = 1'b0;
        jump_now = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MIN_POS;
        cfg_data = '0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        pressure_on = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++)
            run_phase(phase);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[servo_slew_limited_position_unit] OK");
        else
            $display("[servo_slew_limited_position_unit] ERROR");
        $finish;
    end

endmodule
